/* rtl/core/swmf_pkg.sv */
// swmf_pkg: constants, types and sequencer states for the sliding window median filter
// no dependencies; used by swmf_cmp and sliding_window_median_filter_unit
package swmf_pkg;

    localparam int MAX_WINDOW  = 63;
    localparam int SAMPLE_BITS = 16;
    localparam int RESULT_CAP  = 32;
    localparam int SEEN_MAX    = 127;
    localparam int WL_W        = 6;
    localparam int WIN_AW      = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int SEEN_W      = $clog2(SEEN_MAX + 1);
    localparam int RES_W       = $clog2(RESULT_CAP + 1);
    localparam int TOT_W       = CNT_W + 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND_ADDR,
        ST_CAND_LATCH,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr;
        logic en;
    } cmp_ctrl_t;

endpackage

/* rtl/core/swmf_ram.sv */
// swmf_ram: generic single write port, single read port ram with registered read
// no dependencies
module swmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/swmf_cmp.sv */
// swmf_cmp: shared signed compare unit with rank counters (below and not-above)
// depends on swmf_pkg
module swmf_cmp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  swmf_pkg::cmp_ctrl_t        ctrl,
    input  swmf_pkg::sample_t          cand,
    input  swmf_pkg::sample_t          data,
    output logic [swmf_pkg::CNT_W-1:0] below_cnt,
    output logic [swmf_pkg::CNT_W-1:0] nabove_cnt
);

    logic [swmf_pkg::CNT_W-1:0] below_reg;
    logic [swmf_pkg::CNT_W-1:0] below_next;
    logic [swmf_pkg::CNT_W-1:0] nabove_reg;
    logic [swmf_pkg::CNT_W-1:0] nabove_next;
    logic                       lt;
    logic                       le;

    assign lt = data < cand;
    assign le = data <= cand;

    always_comb
    begin
        below_next  = below_reg;
        nabove_next = nabove_reg;
        if (ctrl.clr)
        begin
            below_next  = '0;
            nabove_next = '0;
        end
        else if (ctrl.en)
        begin
            below_next  = below_reg + swmf_pkg::CNT_W'(lt);
            nabove_next = nabove_reg + swmf_pkg::CNT_W'(le);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_reg  <= '0;
            nabove_reg <= '0;
        end
        else
        begin
            below_reg  <= below_next;
            nabove_reg <= nabove_next;
        end
    end

    assign below_cnt  = below_reg;
    assign nabove_cnt = nabove_reg;

endmodule

/* rtl/core/sliding_window_median_filter_unit.sv */
// sliding_window_median_filter_unit: running median filter with edge padding
// depends on swmf_pkg, swmf_ram, swmf_cmp
//
//   channel   | valid         | stall         | payload
//   ----------+---------------+---------------+-----------------------------------
//   sample in | sample_valid  | sample_stall  | sample, last_sample
//   median out| median_valid  | median_stall  | median_value, run_last, stream_last
//   config    | window_length_wr (write enable, no stall) | window_length
//
// a request is taken while the sequencer is idle; if it yields medians, rank selection runs
// over the window ram through one comparator, its duration set by the candidate/scan
// loop over the single ram read port
// each result then takes one cycle unless median_stall holds it
// reset clears the sequencer, counters and sets window length to 5
// sample_stall is high from the cycle after a request that yields medians
// until its last result is taken
module sliding_window_median_filter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            window_length_wr,
    input  logic [swmf_pkg::WL_W-1:0]       window_length,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic signed [swmf_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                            last_sample,
    output logic                            median_valid,
    input  logic                            median_stall,
    output logic signed [swmf_pkg::SAMPLE_BITS-1:0] median_value,
    output logic                            run_last,
    output logic                            stream_last
);

    swmf_pkg::state_t            state_reg;
    swmf_pkg::state_t            state_next;
    logic [swmf_pkg::WL_W-1:0]   wl_reg;
    logic [swmf_pkg::WL_W-1:0]   wl_next;
    logic [swmf_pkg::SEEN_W-1:0] seen_reg;
    logic [swmf_pkg::SEEN_W-1:0] seen_next;
    logic [swmf_pkg::CNT_W-1:0]  ptr_reg;
    logic [swmf_pkg::CNT_W-1:0]  ptr_next;
    logic [swmf_pkg::CNT_W-1:0]  cand_idx_reg;
    logic [swmf_pkg::CNT_W-1:0]  cand_idx_next;
    logic [swmf_pkg::CNT_W-1:0]  j_reg;
    logic [swmf_pkg::CNT_W-1:0]  j_next;
    logic [swmf_pkg::RES_W-1:0]  total_reg;
    logic [swmf_pkg::RES_W-1:0]  total_next;
    logic [swmf_pkg::RES_W-1:0]  emit_cnt_reg;
    logic [swmf_pkg::RES_W-1:0]  emit_cnt_next;
    logic                        is_last_reg;
    logic                        is_last_next;
    swmf_pkg::sample_t           cand_reg;
    swmf_pkg::sample_t           cand_next;
    swmf_pkg::sample_t           median_reg;
    swmf_pkg::sample_t           median_next;

    logic [swmf_pkg::CNT_W-1:0]  w_eff;
    logic [swmf_pkg::CNT_W-1:0]  k_half;
    logic                        odd_w;
    logic [swmf_pkg::SEEN_W-1:0] seen_inc;
    logic [swmf_pkg::TOT_W-1:0]  copies;
    logic [swmf_pkg::TOT_W-1:0]  total_raw;
    logic [swmf_pkg::RES_W-1:0]  total_cap;
    logic [swmf_pkg::CNT_W-1:0]  ptr_inc;
    logic                        accept;
    logic                        found;
    logic                        emit_final;

    logic                        ram_we;
    logic [swmf_pkg::WIN_AW-1:0] ram_rd_addr;
    logic [swmf_pkg::SAMPLE_BITS-1:0] ram_rd_data;
    swmf_pkg::cmp_ctrl_t         cmp_ctrl;
    logic [swmf_pkg::CNT_W-1:0]  below_cnt;
    logic [swmf_pkg::CNT_W-1:0]  nabove_cnt;

    // effective window, clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (wl_reg == '0)
        begin
            w_eff = swmf_pkg::CNT_W'(1);
        end
        else if (swmf_pkg::CNT_W'(wl_reg) > swmf_pkg::CNT_W'(swmf_pkg::MAX_WINDOW))
        begin
            w_eff = swmf_pkg::CNT_W'(swmf_pkg::MAX_WINDOW);
        end
        else
        begin
            w_eff = swmf_pkg::CNT_W'(wl_reg);
        end
    end

    assign k_half   = w_eff >> 1;
    assign odd_w    = w_eff[0];
    assign seen_inc = (seen_reg == swmf_pkg::SEEN_W'(swmf_pkg::SEEN_MAX)) ?
                      seen_reg : seen_reg + swmf_pkg::SEEN_W'(1);
    assign ptr_inc  = ptr_reg + swmf_pkg::CNT_W'(1);
    assign accept   = sample_valid && (state_reg == swmf_pkg::ST_IDLE);

    // head copies for the first usable window, none before it, one copy otherwise
    always_comb
    begin
        copies = '0;
        if (seen_inc >= swmf_pkg::SEEN_W'(w_eff))
        begin
            if (seen_inc == swmf_pkg::SEEN_W'(w_eff))
            begin
                copies = odd_w ? swmf_pkg::TOT_W'(k_half) + swmf_pkg::TOT_W'(1) : '0;
            end
            else if (!odd_w && (seen_inc == swmf_pkg::SEEN_W'(w_eff) + swmf_pkg::SEEN_W'(1)))
            begin
                copies = swmf_pkg::TOT_W'(k_half) + swmf_pkg::TOT_W'(1);
            end
            else
            begin
                copies = swmf_pkg::TOT_W'(1);
            end
        end
    end

    assign total_raw = (last_sample && (copies != '0)) ?
                       copies + swmf_pkg::TOT_W'(k_half) : copies;
    assign total_cap = (total_raw > swmf_pkg::TOT_W'(swmf_pkg::RESULT_CAP)) ?
                       swmf_pkg::RES_W'(swmf_pkg::RESULT_CAP) : swmf_pkg::RES_W'(total_raw);

    assign found      = (below_cnt <= k_half) && (k_half < nabove_cnt);
    assign emit_final = (emit_cnt_reg == total_reg - swmf_pkg::RES_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swmf_pkg::ST_IDLE:
            begin
                if (accept && (copies != '0))
                begin
                    state_next = swmf_pkg::ST_CAND_ADDR;
                end
            end
            swmf_pkg::ST_CAND_ADDR:
            begin
                state_next = swmf_pkg::ST_CAND_LATCH;
            end
            swmf_pkg::ST_CAND_LATCH:
            begin
                state_next = swmf_pkg::ST_SCAN;
            end
            swmf_pkg::ST_SCAN:
            begin
                if (j_reg == w_eff)
                begin
                    state_next = swmf_pkg::ST_CHECK;
                end
            end
            swmf_pkg::ST_CHECK:
            begin
                state_next = found ? swmf_pkg::ST_EMIT : swmf_pkg::ST_CAND_ADDR;
            end
            swmf_pkg::ST_EMIT:
            begin
                if (!median_stall && emit_final)
                begin
                    state_next = swmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmf_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        wl_next       = wl_reg;
        seen_next     = seen_reg;
        ptr_next      = ptr_reg;
        cand_idx_next = cand_idx_reg;
        j_next        = j_reg;
        total_next    = total_reg;
        emit_cnt_next = emit_cnt_reg;
        is_last_next  = is_last_reg;
        cand_next     = cand_reg;
        median_next   = median_reg;
        ram_we        = 1'b0;
        ram_rd_addr   = '0;
        cmp_ctrl      = '0;
        case (state_reg)
            swmf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ram_we        = 1'b1;
                    ptr_next      = (ptr_inc == w_eff) ? '0 : ptr_inc;
                    seen_next     = last_sample ? '0 : seen_inc;
                    total_next    = total_cap;
                    is_last_next  = last_sample;
                    cand_idx_next = '0;
                end
                if (window_length_wr)
                begin
                    wl_next   = window_length;
                    seen_next = '0;
                    ptr_next  = '0;
                end
            end
            swmf_pkg::ST_CAND_ADDR:
            begin
                ram_rd_addr = cand_idx_reg[swmf_pkg::WIN_AW-1:0];
            end
            swmf_pkg::ST_CAND_LATCH:
            begin
                cand_next    = $signed(ram_rd_data);
                ram_rd_addr  = '0;
                j_next       = swmf_pkg::CNT_W'(1);
                cmp_ctrl.clr = 1'b1;
            end
            swmf_pkg::ST_SCAN:
            begin
                cmp_ctrl.en = 1'b1;
                if (j_reg < w_eff)
                begin
                    ram_rd_addr = j_reg[swmf_pkg::WIN_AW-1:0];
                    j_next      = j_reg + swmf_pkg::CNT_W'(1);
                end
            end
            swmf_pkg::ST_CHECK:
            begin
                if (found)
                begin
                    median_next   = cand_reg;
                    emit_cnt_next = '0;
                end
                else
                begin
                    cand_idx_next = cand_idx_reg + swmf_pkg::CNT_W'(1);
                end
            end
            swmf_pkg::ST_EMIT:
            begin
                if (!median_stall)
                begin
                    emit_cnt_next = emit_cnt_reg + swmf_pkg::RES_W'(1);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= swmf_pkg::ST_IDLE;
            wl_reg       <= swmf_pkg::WL_W'(5);
            seen_reg     <= '0;
            ptr_reg      <= '0;
            cand_idx_reg <= '0;
            j_reg        <= '0;
            total_reg    <= '0;
            emit_cnt_reg <= '0;
            is_last_reg  <= 1'b0;
            median_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            wl_reg       <= wl_next;
            seen_reg     <= seen_next;
            ptr_reg      <= ptr_next;
            cand_idx_reg <= cand_idx_next;
            j_reg        <= j_next;
            total_reg    <= total_next;
            emit_cnt_reg <= emit_cnt_next;
            is_last_reg  <= is_last_next;
            median_reg   <= median_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    swmf_ram #(
        .WIDTH (swmf_pkg::SAMPLE_BITS),
        .DEPTH (swmf_pkg::MAX_WINDOW)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ptr_reg[swmf_pkg::WIN_AW-1:0]),
        .wr_data (sample),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    swmf_cmp u_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cmp_ctrl),
        .cand       (cand_reg),
        .data       ($signed(ram_rd_data)),
        .below_cnt  (below_cnt),
        .nabove_cnt (nabove_cnt)
    );

    assign sample_stall = (state_reg != swmf_pkg::ST_IDLE);
    assign median_valid = (state_reg == swmf_pkg::ST_EMIT);
    assign median_value = median_reg;
    assign run_last     = median_valid && emit_final;
    assign stream_last  = run_last && is_last_reg;

    // no new request while results are pending
    a_no_accept_during_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        median_valid |-> sample_stall
    ) else $error("sample accepted while results pending");

    // result counter stays inside the run
    a_emit_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        median_valid |-> (emit_cnt_reg < total_reg)
    ) else $error("result counter beyond run length");

    // rank counters are ordered when checked
    a_rank_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == swmf_pkg::ST_CHECK) |-> (below_cnt < nabove_cnt)
    ) else $error("rank counters out of order");

    // the run ends after its last result is taken
    a_run_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (median_valid && !median_stall && run_last) |=> !median_valid
    ) else $error("results continue past run end");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for sliding_window_median_filter_unit
// depends on swmf_pkg and the rtl/core sources; predicts every median in the bench itself
// and compares each one, field by field, against the dut output stream
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 48;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        swmf_pkg::sample_t value;
        logic              run_last;
        logic              stream_last;
    } median_exp_t;

    logic                      clk;
    logic                      rst_n;
    logic                      window_length_wr;
    logic [swmf_pkg::WL_W-1:0] window_length;
    logic                      sample_valid;
    logic                      sample_stall;
    swmf_pkg::sample_t         sample;
    logic                      last_sample;
    logic                      median_valid;
    logic                      median_stall;
    swmf_pkg::sample_t         median_value;
    logic                      run_last;
    logic                      stream_last;

    median_exp_t       pending_medians[$];
    swmf_pkg::sample_t win_samples[swmf_pkg::MAX_WINDOW];
    int                win_seen;
    swmf_pkg::sample_t held_median;
    int                cur_window;

    int errors;
    int samples_sent;
    int medians_checked;
    int settings_used;
    int hold_req;
    bit no_idle;

    sliding_window_median_filter_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .window_length_wr (window_length_wr),
        .window_length    (window_length),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .sample           (sample),
        .last_sample      (last_sample),
        .median_valid     (median_valid),
        .median_stall     (median_stall),
        .median_value     (median_value),
        .run_last         (run_last),
        .stream_last      (stream_last)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic swmf_pkg::sample_t window_rank(input int w, input int r);
        swmf_pkg::sample_t sorted[swmf_pkg::MAX_WINDOW];
        swmf_pkg::sample_t t;
        int                i;
        int                j;
        for (i = 0; i < w; i++)
            sorted[i] = win_samples[i];
        for (i = 1; i < w; i++)
        begin
            t = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > t)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = t;
        end
        return sorted[r];
    endfunction

    function automatic void predict_medians(input swmf_pkg::sample_t value, input logic last);
        int          w;
        int          k;
        int          copies;
        int          total;
        median_exp_t m;
        w = (cur_window == 0) ? 1 : cur_window;
        if (w > swmf_pkg::MAX_WINDOW)
            w = swmf_pkg::MAX_WINDOW;
        k = w / 2;
        copies = 0;
        for (int j = 0; j + 1 < w; j++)
            win_samples[j] = win_samples[j + 1];
        win_samples[w - 1] = value;
        if (win_seen < swmf_pkg::SEEN_MAX)
            win_seen++;
        if (win_seen >= w)
        begin
            if (win_seen == w)
                copies = (w % 2 == 1) ? k + 1 : 0;
            else if (w % 2 == 0 && win_seen == w + 1)
                copies = k + 1;
            else
                copies = 1;
            if (copies > 0)
                held_median = window_rank(w, k);
        end
        total = copies;
        if (last)
        begin
            if (copies > 0)
                total += k;
            win_seen = 0;
        end
        if (total > swmf_pkg::RESULT_CAP)
            total = swmf_pkg::RESULT_CAP;
        for (int r = 0; r < total; r++)
        begin
            m.value       = held_median;
            m.run_last    = (r + 1 == total);
            m.stream_last = (r + 1 == total) && last;
            pending_medians.push_back(m);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic swmf_pkg::sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return swmf_pkg::sample_t'(-32768);
            1: return swmf_pkg::sample_t'(32767);
            2, 3, 4: return swmf_pkg::sample_t'($signed($urandom_range(0, 15)) - 8);
            default: return swmf_pkg::sample_t'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
        errors++;
    endtask

    task automatic send_sample(input swmf_pkg::sample_t value, input logic last);
        int gap;
        sample       = value;
        last_sample  = last;
        sample_valid = 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predict_medians(value, last);
        samples_sent++;
        @(negedge clk);
        gap = 0;
        if (!no_idle && $urandom_range(0, 1))
            gap = pick_gap();
        if (gap > 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_stream(input int len, input bit terminate);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), terminate && (i == len - 1));
    endtask

    task automatic wait_drained();
        sample_valid = 1'b0;
        while (pending_medians.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_window(input int w);
        int active;
        int pause;
        wait_drained();
        active = (cur_window == 0) ? 1 : cur_window;
        pause = active * (active + 3) + 16;
        repeat (pause) @(negedge clk);
        window_length_wr = 1'b1;
        window_length    = w[swmf_pkg::WL_W-1:0];
        @(negedge clk);
        window_length_wr = 1'b0;
        cur_window = w;
        win_seen   = 0;
        settings_used++;
    endtask

    task automatic test_reset_window();
        send_sample(swmf_pkg::sample_t'(-32768), 1'b0);
        send_sample(swmf_pkg::sample_t'(32767), 1'b0);
        send_sample(swmf_pkg::sample_t'(0), 1'b0);
        send_sample(swmf_pkg::sample_t'(-1), 1'b0);
        send_sample(swmf_pkg::sample_t'(1), 1'b1);
    endtask

    task automatic test_short_stream();
        send_sample(swmf_pkg::sample_t'(100), 1'b0);
        send_sample(swmf_pkg::sample_t'(-100), 1'b0);
        send_sample(swmf_pkg::sample_t'(7), 1'b1);
    endtask

    task automatic test_even_window();
        set_window(4);
        send_sample(swmf_pkg::sample_t'(5), 1'b0);
        send_sample(swmf_pkg::sample_t'(-3), 1'b0);
        send_sample(swmf_pkg::sample_t'(5), 1'b0);
        send_sample(swmf_pkg::sample_t'(32767), 1'b0);
        send_sample(swmf_pkg::sample_t'(-32768), 1'b0);
        send_sample(swmf_pkg::sample_t'(2), 1'b1);
        send_stream(4, 1'b1);
    endtask

    task automatic test_zero_window();
        set_window(0);
        send_sample(swmf_pkg::sample_t'(-32768), 1'b0);
        send_sample(swmf_pkg::sample_t'(32767), 1'b0);
        send_sample(swmf_pkg::sample_t'(-2), 1'b1);
    endtask

    task automatic test_restart_on_write();
        set_window(3);
        send_stream(2, 1'b0);
        set_window(3);
        send_stream(3, 1'b1);
    endtask

    task automatic test_window_extremes();
        set_window(63);
        send_stream(63, 1'b1);
        set_window(1);
        send_stream(3, 1'b1);
    endtask

    task automatic test_backpressure();
        set_window(3);
        no_idle  = 1'b1;
        hold_req = HOLD_CYCLES;
        send_stream(12, 1'b1);
        wait_drained();
        no_idle = 1'b0;
        send_stream(8, 1'b1);
    endtask

    task automatic test_random();
        int rand_items;
        int w;
        int len;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = $urandom_range(11, 24);
                default: w = $urandom_range(1, 10);
            endcase
            set_window(w);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 4))
            begin
                if (rand_items < RANDOM_ITEMS)
                begin
                    if ($urandom_range(0, 9) < 7)
                        len = $urandom_range((w == 0) ? 1 : w, w + 10);
                    else
                        len = $urandom_range(1, (w < 2) ? 1 : w);
                    if (len > RANDOM_ITEMS - rand_items)
                        len = RANDOM_ITEMS - rand_items;
                    send_stream(len, 1'b1);
                    rand_items += len;
                end
            end
            if (rand_items < RANDOM_ITEMS && $urandom_range(0, 1))
            begin
                len = $urandom_range(1, w + 4);
                if (len > RANDOM_ITEMS - rand_items)
                    len = RANDOM_ITEMS - rand_items;
                send_stream(len, 1'b0);
                rand_items += len;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        median_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                median_stall = 1'b1;
                repeat (hold_req) @(negedge clk);
                hold_req     = 0;
                median_stall = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 25)
            begin
                median_stall = 1'b1;
                repeat (pick_gap()) @(negedge clk);
                median_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        median_exp_t m;
        if (rst_n && median_valid && !median_stall)
        begin
            if (pending_medians.size() == 0)
                report_mismatch("unexpected median", 0, median_value);
            else
            begin
                m = pending_medians.pop_front();
                if (median_value !== m.value)
                    report_mismatch("median_value", m.value, median_value);
                if (run_last !== m.run_last)
                    report_mismatch("run_last", m.run_last, run_last);
                if (stream_last !== m.stream_last)
                    report_mismatch("stream_last", m.stream_last, stream_last);
            end
            medians_checked++;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (median_valid && !median_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("** sliding_window_median_filter_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        window_length_wr = 1'b0;
        window_length    = '0;
        sample_valid     = 1'b0;
        sample           = '0;
        last_sample      = 1'b0;
        errors           = 0;
        samples_sent     = 0;
        medians_checked  = 0;
        settings_used    = 0;
        hold_req         = 0;
        no_idle          = 1'b0;
        cur_window       = 5;
        win_seen         = 0;
        held_median      = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_window();
        test_short_stream();
        test_even_window();
        test_zero_window();
        test_restart_on_write();
        test_window_extremes();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (64) @(negedge clk);
        if (pending_medians.size() != 0)
            report_mismatch("medians still pending", 0, pending_medians.size());
        $display("sent %0d samples under %0d window settings, checked %0d medians",
                 samples_sent, settings_used, medians_checked);
        $display("windows 0 to 63, odd and even, short, long and unterminated streams, capped output");
        if (errors == 0)
            $display("** sliding_window_median_filter_unit: PASSED **");
        else
            $display("** sliding_window_median_filter_unit: FAILED **");
        $finish;
    end

endmodule
